FILE: src/crcfa_pkg.sv
// Shared types, constants and the bytewise CRC-16 update for the frame block.
package crcfa_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_LOW  = 2'd1;
  localparam logic [1:0] TAIL_HIGH = 2'd2;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        echo_last;
    logic        echo_ok;
    logic [15:0] echo_value;
    logic        tail_en;
    logic [15:0] tail_crc;
  } frame_res_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
    logic [15:0] crc;
    crc = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

FILE: src/crcfa_frame.sv
// Per-frame CRC state and the result of one accepted byte.
module crcfa_frame import crcfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       check_mode,
  output frame_res_t res
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] prev_crc_r, prev_crc_nxt;
  logic [7:0]  hist_r, hist_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [15:0] crc_new;
  logic [15:0] rx_val;
  logic [15:0] sw_val;
  logic        long_frame;

  assign crc_new    = crc_update(crc_r, data_byte);
  assign long_frame = (count_r >= 2'd2);
  assign rx_val     = {data_byte, hist_r};
  assign sw_val     = swap16(prev_crc_r);

  always_comb begin
    res.echo_byte  = data_byte;
    res.echo_last  = 1'b0;
    res.echo_ok    = 1'b0;
    res.echo_value = 16'h0000;
    res.tail_en    = 1'b0;
    res.tail_crc   = crc_new;
    if (last_byte) begin
      if (check_mode) begin
        res.echo_last = 1'b1;
        if (long_frame) begin
          res.echo_ok    = (rx_val == sw_val);
          res.echo_value = sw_val;
        end
      end else begin
        res.tail_en = 1'b1;
      end
    end
  end

  always_comb begin
    crc_nxt      = crc_r;
    prev_crc_nxt = prev_crc_r;
    hist_nxt     = hist_r;
    count_nxt    = count_r;
    if (accept) begin
      if (last_byte) begin
        crc_nxt      = CRC_INIT;
        prev_crc_nxt = CRC_INIT;
        hist_nxt     = 8'h00;
        count_nxt    = 2'd0;
      end else begin
        crc_nxt      = crc_new;
        prev_crc_nxt = crc_r;
        hist_nxt     = data_byte;
        count_nxt    = (count_r == 2'd3) ? count_r : count_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      prev_crc_r <= CRC_INIT;
      hist_r     <= 8'h00;
      count_r    <= 2'd0;
    end else begin
      crc_r      <= crc_nxt;
      prev_crc_r <= prev_crc_nxt;
      hist_r     <= hist_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

FILE: src/crc16_frame_append_check.sv
// Top level: CRC-16 frame append and check with a registered result stage.
// A result is registered and valid in the cycle after the input transfer.
// Throughput: one byte per cycle while the output is not stalled; in append
// mode the final byte of a frame holds the input while the two CRC bytes go out.
// Reset (synchronous, active low) clears the mode, the frame CRC state, the
// result valid flag and the pending CRC byte state; the result data is not reset.
module crc16_frame_append_check import crcfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_crc_ok,
  output logic [15:0] out_crc_value
);

  logic        check_mode_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [15:0] out_value_r, out_value_nxt;
  logic [1:0]  tail_cnt_r, tail_cnt_nxt;
  logic [15:0] tail_crc_r, tail_crc_nxt;
  logic        in_fire;
  logic        out_fire;
  frame_res_t  res;

  assign in_ready = (tail_cnt_r == TAIL_NONE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  crcfa_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_fire),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .check_mode (check_mode_r),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    tail_cnt_nxt  = tail_cnt_r;
    tail_crc_nxt  = tail_crc_r;
    if (out_fire && tail_cnt_r == TAIL_HIGH) begin
      out_byte_nxt  = tail_crc_r[15:8];
      out_last_nxt  = 1'b0;
      out_ok_nxt    = 1'b0;
      out_value_nxt = 16'h0000;
      tail_cnt_nxt  = TAIL_LOW;
    end else if (out_fire && tail_cnt_r == TAIL_LOW) begin
      out_byte_nxt  = tail_crc_r[7:0];
      out_last_nxt  = 1'b1;
      out_ok_nxt    = 1'b0;
      out_value_nxt = swap16(tail_crc_r);
      tail_cnt_nxt  = TAIL_NONE;
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = res.echo_byte;
      out_last_nxt  = res.echo_last;
      out_ok_nxt    = res.echo_ok;
      out_value_nxt = res.echo_value;
      tail_crc_nxt  = res.tail_crc;
      tail_cnt_nxt  = res.tail_en ? TAIL_HIGH : TAIL_NONE;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
      tail_cnt_r   <= TAIL_NONE;
    end else begin
      if (cfg_wr_en) begin
        check_mode_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      tail_cnt_r  <= tail_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
    tail_crc_r  <= tail_crc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_crc_ok    = out_ok_r;
  assign out_crc_value = out_value_r;

  // Pending CRC bytes always sit behind a valid result.
  a_tail_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r != TAIL_NONE) |-> out_valid_r)
    else $error("CRC bytes pending without a valid result");

  // No transfer is taken while CRC bytes are still to go out.
  a_no_accept_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r != TAIL_NONE) |-> !in_ready)
    else $error("input ready while CRC bytes pending");

  // Every input transfer yields a valid result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("input transfer produced no result");

  // A set match flag only appears on the final result of a frame.
  a_ok_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r) |-> out_last_r)
    else $error("crc_ok set on a result that is not final");

endmodule
